/* src/wcm_pkg.sv */
// ----------------------------------------------------------------------------
// wcm_pkg
// shared types, field widths, codes and width helpers for the wall column
// texel mapper
// ----------------------------------------------------------------------------
package wcm_pkg;

  // fixed field widths
  localparam int FACE_W    = 2;
  localparam int FRAC_IN_W = 16;
  localparam int LH_W      = 16;
  localparam int ROW_W     = 9;
  localparam int TEX_W     = 11;
  localparam int OUT_W     = 10;
  localparam int CFG_IDX_W = 1;

  // parameter defaults
  localparam int SCREEN_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF     = 16;

  // texture size after reset
  localparam logic [TEX_W-1:0] TEX_SIZE_RESET = 11'd64;

  // largest texel coordinate on the result ports
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // hit face codes
  localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
  localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;
  localparam logic [FACE_W-1:0] FACE_EAST  = 2'd2;
  localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'd1;

  // input transaction
  typedef struct packed {
    logic [FACE_W-1:0]    face;
    logic [FRAC_IN_W-1:0] wall_frac;
    logic [LH_W-1:0]      line_height;
    logic [ROW_W-1:0]     screen_row;
  } item_t;

  // result transaction
  typedef struct packed {
    logic             draw;
    logic [OUT_W-1:0] texel_col;
    logic [OUT_W-1:0] texel_row;
  } result_t;

  // row classification carried down the pipeline
  typedef struct packed {
    logic in_span;
    logic centre;
    logic upper;
    logic lh_zero;
  } row_ctl_t;

  // bits for the distance of a row from the centre, up to the centre itself
  function automatic int k_bits(input int screen_height);
    k_bits = $clog2(screen_height / 2 + 1);
  endfunction

  // bits that hold both a screen row and the screen height
  function automatic int dist_bits(input int screen_height);
    int w;
    w = $clog2(screen_height) + 1;
    dist_bits = (w > ROW_W + 1) ? w : ROW_W + 1;
  endfunction

endpackage

/* src/wcm_front.sv */
// ----------------------------------------------------------------------------
// wcm_front
// two input stages: texel column product and row classification, then
// column mirroring and saturation
// ----------------------------------------------------------------------------
module wcm_front import wcm_pkg::*; #(
  parameter  int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  localparam int KW            = k_bits(SCREEN_HEIGHT)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [TEX_W-1:0] tex_width_i,
  output logic             valid_o,
  output logic [OUT_W-1:0] col_o,
  output row_ctl_t         ctl_o,
  output logic [KW-1:0]    k_o,
  output logic [LH_W-1:0]  lh_o
);

  localparam int Centre = SCREEN_HEIGHT / 2;
  localparam int DistW  = dist_bits(SCREEN_HEIGHT);
  localparam int CmpW   = (DistW > LH_W) ? DistW : LH_W;
  localparam int ProdW  = FRAC_IN_W + TEX_W;

  logic [DistW-1:0]    row_ext;
  logic [DistW-1:0]    k_full;
  logic [LH_W-2:0]     half;
  row_ctl_t            ctl_d;

  logic                v1_q;
  logic [ProdW-1:0]    prod_q;
  logic [FACE_W-1:0]   face_q;
  row_ctl_t            ctl1_q;
  logic [KW-1:0]       k1_q;
  logic [LH_W-1:0]     lh1_q;

  logic [TEX_W-1:0]    col_raw;
  logic [TEX_W-1:0]    col_full;
  logic [OUT_W-1:0]    col_d;

  logic                v2_q;
  logic [OUT_W-1:0]    col_q;
  row_ctl_t            ctl2_q;
  logic [KW-1:0]       k2_q;
  logic [LH_W-1:0]     lh2_q;

  // row against the centre and the clamped span
  always_comb begin
    row_ext       = DistW'(item_i.screen_row);
    half          = item_i.line_height[LH_W-1:1];
    ctl_d.upper   = row_ext < DistW'(Centre);
    ctl_d.centre  = row_ext == DistW'(Centre);
    k_full        = ctl_d.upper ? DistW'(Centre) - row_ext : row_ext - DistW'(Centre);
    ctl_d.in_span = (row_ext < DistW'(SCREEN_HEIGHT)) && (CmpW'(k_full) <= CmpW'(half));
    ctl_d.lh_zero = item_i.line_height == '0;
  end

  // stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(item_i.wall_frac) * ProdW'(tex_width_i);
    face_q <= item_i.face;
    ctl1_q <= ctl_d;
    k1_q   <= k_full[KW-1:0];
    lh1_q  <= item_i.line_height;
  end

  // column: truncate, mirror for north and east, zero for a zero width, saturate
  always_comb begin
    col_raw  = prod_q[FRAC_IN_W +: TEX_W];
    col_full = col_raw;
    if (tex_width_i == '0) begin
      col_full = '0;
    end else if (face_q == FACE_NORTH || face_q == FACE_EAST) begin
      col_full = tex_width_i - col_raw - TEX_W'(1);
    end
    col_d = (col_full > TEX_W'(OUT_MAX)) ? OUT_MAX : col_full[OUT_W-1:0];
  end

  // stage 2 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    ctl2_q <= ctl1_q;
    k2_q   <= k1_q;
    lh2_q  <= lh1_q;
  end

  assign valid_o = v2_q;
  assign col_o   = col_q;
  assign ctl_o   = ctl2_q;
  assign k_o     = k2_q;
  assign lh_o    = lh2_q;

endmodule

/* src/wcm_div.sv */
// ----------------------------------------------------------------------------
// wcm_div
// pipelined restoring divider, one quotient bit per stage, with a side
// payload that travels alongside each transaction
// ----------------------------------------------------------------------------
module wcm_div import wcm_pkg::*; #(
  parameter int NumW  = TEX_W + FRAC_BITS_DEF,
  parameter int DenW  = LH_W,
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_q  [NumW];
  logic [DenW-1:0]  rem_q  [NumW];
  logic [NumW-1:0]  num_q  [NumW];
  logic [NumW-1:0]  quo_q  [NumW];
  logic [DenW-1:0]  den_q  [NumW];
  logic [SideW-1:0] side_q [NumW];

  for (genvar j = 0; j < NumW; j++) begin : g_stage
    logic             vld_in;
    logic [DenW-1:0]  rem_in;
    logic [NumW-1:0]  num_in;
    logic [NumW-1:0]  quo_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [DenW:0]    trial;
    logic             ge;

    // stage inputs
    if (j == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign num_in  = num_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    // bring down the next dividend bit and try the subtraction
    assign trial = {rem_in, num_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= ge ? DenW'(trial - {1'b0, den_in}) : trial[DenW-1:0];
      num_q[j]  <= num_in << 1;
      quo_q[j]  <= {quo_in[NumW-2:0], ge};
      den_q[j]  <= den_in;
      side_q[j] <= side_in;
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = quo_q[NumW-1];
  assign side_o  = side_q[NumW-1];

  // the final remainder is always below a nonzero divisor
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumW-1] && (den_q[NumW-1] != '0) |-> rem_q[NumW-1] < den_q[NumW-1])
    else $error("divider remainder not below divisor");

endmodule

/* src/wcm_row.sv */
// ----------------------------------------------------------------------------
// wcm_row
// texel row: offset product k times step, then the row from the texture
// centre, draw decision and the result register
// ----------------------------------------------------------------------------
module wcm_row import wcm_pkg::*; #(
  parameter  int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter  int FRAC_BITS     = FRAC_BITS_DEF,
  localparam int KW            = k_bits(SCREEN_HEIGHT),
  localparam int QW            = TEX_W + FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  row_ctl_t         ctl_i,
  input  logic [KW-1:0]    k_i,
  input  logic [OUT_W-1:0] col_i,
  input  logic [QW-1:0]    step_i,
  input  logic [TEX_W-1:0] tex_height_i,
  output logic             result_valid_o,
  output result_t          result_o
);

  localparam int OffW = KW + QW;
  localparam int SumW = OffW + 1;
  localparam int TexW = SumW - FRAC_BITS;

  logic             v1_q;
  logic [OffW-1:0]  off_q;
  row_ctl_t         ctl_q;
  logic [OUT_W-1:0] col_q;

  logic [SumW-1:0]  base;
  logic [SumW-1:0]  one;
  logic [SumW-1:0]  off_ext;
  logic [SumW-1:0]  up_diff;
  logic [SumW-1:0]  lo_sum;
  logic [TexW-1:0]  texel_full;
  logic             draw_d;
  logic [OUT_W-1:0] texel_sat;
  result_t          res_d;

  logic             out_vld_q;
  result_t          res_q;

  // offset stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  // offset from the centre row in texture fixed point
  always_ff @(posedge clk_i) begin
    off_q <= OffW'(k_i) * OffW'(step_i);
    ctl_q <= ctl_i;
    col_q <= col_i;
  end

  // centre of the texture and the two directions from it
  assign base    = SumW'({tex_height_i[TEX_W-1:1], {FRAC_BITS{1'b0}}});
  assign one     = SumW'(1) << FRAC_BITS;
  assign off_ext = SumW'(off_q);
  assign up_diff = base - off_ext;
  assign lo_sum  = base + off_ext;

  // row and draw decision
  always_comb begin
    draw_d     = 1'b0;
    texel_full = '0;
    if ((tex_height_i != '0) && ctl_q.in_span) begin
      if (ctl_q.centre) begin
        texel_full = TexW'(tex_height_i >> 1);
        draw_d     = 1'b1;
      end else if (!ctl_q.lh_zero) begin
        if (ctl_q.upper) begin
          // above the centre: a row just below zero truncates to zero
          if (off_ext <= base) begin
            texel_full = up_diff[SumW-1:FRAC_BITS];
            draw_d     = 1'b1;
          end else if (off_ext < base + one) begin
            draw_d     = 1'b1;
          end
        end else begin
          // below the centre: stop at the bottom of the texture
          texel_full = lo_sum[SumW-1:FRAC_BITS];
          draw_d     = texel_full < TexW'(tex_height_i);
        end
      end
    end
    texel_sat       = (texel_full > TexW'(OUT_MAX)) ? OUT_MAX : texel_full[OUT_W-1:0];
    res_d.draw      = draw_d;
    res_d.texel_col = col_q;
    res_d.texel_row = draw_d ? texel_sat : '0;
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= v1_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = res_q;

  // an undrawn row reports texel row zero
  a_undrawn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.draw |-> res_q.texel_row == '0)
    else $error("undrawn row with nonzero texel row");

  // a drawn row lies inside the texture
  a_drawn_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.draw |-> TEX_W'(res_q.texel_row) < tex_height_i)
    else $error("drawn texel row outside the texture");

endmodule

/* src/wall_column_texel_mapper.sv */
// the step divider has 11 + FRAC_BITS stages, one quotient bit each
// throughput: one transaction per clock, busy is never raised
// reset: clears every valid bit and sets the texture size to 64 by 64
// ----------------------------------------------------------------------------
// wall_column_texel_mapper
// texel column and row, and draw flag, for one pixel of a raycast wall column
// ----------------------------------------------------------------------------
module wall_column_texel_mapper import wcm_pkg::*; #(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TEX_W-1:0]     cfg_data_i
);

  localparam int KW      = k_bits(SCREEN_HEIGHT);
  localparam int QW      = TEX_W + FRAC_BITS;
  localparam int SideW   = $bits(row_ctl_t) + KW + OUT_W;
  localparam int Latency = QW + 4;

  logic [TEX_W-1:0] tex_width_q;
  logic [TEX_W-1:0] tex_height_q;

  logic             front_vld;
  logic [OUT_W-1:0] front_col;
  row_ctl_t         front_ctl;
  logic [KW-1:0]    front_k;
  logic [LH_W-1:0]  front_lh;

  logic             div_vld;
  logic [QW-1:0]    div_quo;
  logic [SideW-1:0] div_side;
  row_ctl_t         div_ctl;
  logic [KW-1:0]    div_k;
  logic [OUT_W-1:0] div_col;

  // no stall anywhere: a transaction is taken on every start
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // texture size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= TEX_SIZE_RESET;
      tex_height_q <= TEX_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TEX_WIDTH:  tex_width_q  <= cfg_data_i;
        REG_TEX_HEIGHT: tex_height_q <= cfg_data_i;
        default:        tex_width_q  <= tex_width_q;
      endcase
    end
  end

  // column and span classification
  wcm_front #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start && !busy),
    .item_i      (item_i),
    .tex_width_i (tex_width_q),
    .valid_o     (front_vld),
    .col_o       (front_col),
    .ctl_o       (front_ctl),
    .k_o         (front_k),
    .lh_o        (front_lh)
  );

  // vertical step: tex_height in fixed point over line height
  wcm_div #(
    .NumW  (QW),
    .DenW  (LH_W),
    .SideW (SideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .num_i   ({tex_height_q, {FRAC_BITS{1'b0}}}),
    .den_i   (front_lh),
    .side_i  ({front_ctl, front_k, front_col}),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  assign {div_ctl, div_k, div_col} = div_side;

  // texel row and result register
  wcm_row #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_row (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (div_vld),
    .ctl_i          (div_ctl),
    .k_i            (div_k),
    .col_i          (div_col),
    .step_i         (div_quo),
    .tex_height_i   (tex_height_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // every accepted transaction gives a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency result_valid_o)
    else $error("accepted transaction without result");

  // no result without an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, Latency))
    else $error("result without accepted transaction");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wall column texel mapper: pixel transactions go
// in from a queue with random gaps, every result strobe is checked field by
// field against an in-bench prediction, over several texture size settings
// ----------------------------------------------------------------------------
module tb import wcm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_H   = 512;
  localparam int FRAC       = 16;
  localparam int CENTRE_ROW = SCREEN_H / 2;
  localparam int LATENCY    = FRAC + 15;
  localparam int ROUNDS     = 8;
  localparam int ROUND_PIX  = 110;
  localparam int PRINT_CAP  = 40;
  localparam longint unsigned RUN_LIMIT_NS = 1_000_000;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // block ports
  logic                 start       = 1'b0;
  logic                 busy;
  item_t                item_i      = '0;
  logic                 result_valid_o;
  result_t              result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_TEX_WIDTH;
  logic [TEX_W-1:0]     cfg_data_i  = '0;

  wall_column_texel_mapper #(
    .SCREEN_HEIGHT(SCREEN_H),
    .FRAC_BITS    (FRAC)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // bench copy of the texture size registers
  logic [TEX_W-1:0] tex_w_cfg = TEX_SIZE_RESET;
  logic [TEX_W-1:0] tex_h_cfg = TEX_SIZE_RESET;

  item_t   pixel_q[$];
  result_t texel_q[$];

  int unsigned mismatch_count = 0;
  int unsigned pixels_checked = 0;
  int unsigned settings_done  = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP)
      $display("tb: mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // expected texel coordinates and draw flag for one pixel
  function automatic result_t predict_texel(input item_t px);
    longint unsigned tw, th, lh, row, half, lo, hi, base, stepv, off, texel, col;
    logic    draw;
    result_t r;
    tw    = tex_w_cfg;
    th    = tex_h_cfg;
    lh    = px.line_height;
    row   = px.screen_row;
    half  = lh / 2;
    lo    = (half > CENTRE_ROW) ? 0 : CENTRE_ROW - half;
    hi    = CENTRE_ROW + half;
    base  = (th / 2) << FRAC;
    texel = 0;
    draw  = 1'b0;
    if (hi > SCREEN_H - 1)
      hi = SCREEN_H - 1;

    // texel column, mirrored for north and east faces
    if (tw == 0) begin
      col = 0;
    end else begin
      col = (longint'(px.wall_frac) * tw) >> 16;
      if (px.face == FACE_NORTH || px.face == FACE_EAST)
        col = tw - col - 1;
    end
    if (col > OUT_MAX)
      col = OUT_MAX;

    // texel row stepped out from the centre row
    if (th != 0 && row >= lo && row <= hi && row < SCREEN_H) begin
      if (row == CENTRE_ROW) begin
        texel = th / 2;
        draw  = 1'b1;
      end else if (lh != 0) begin
        stepv = (th << FRAC) / lh;
        if (row < CENTRE_ROW) begin
          off = (CENTRE_ROW - row) * stepv;
          if (off <= base) begin
            texel = (base - off) >> FRAC;
            draw  = 1'b1;
          end else if (off - base < (64'd1 << FRAC)) begin
            // just below zero, truncated toward zero
            texel = 0;
            draw  = 1'b1;
          end
        end else begin
          off   = (row - CENTRE_ROW) * stepv;
          texel = (base + off) >> FRAC;
          draw  = texel < th;
        end
      end
    end
    if (texel > OUT_MAX)
      texel = OUT_MAX;

    r           = '0;
    r.draw      = draw;
    r.texel_col = col[OUT_W-1:0];
    r.texel_row = draw ? texel[OUT_W-1:0] : '0;
    return r;
  endfunction

  // driver: one pixel transaction per start, random idle gaps with calm stretches
  int unsigned idle_left;
  int unsigned calm_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      item_i    <= '0;
      idle_left <= 0;
      calm_left <= 0;
    end else if (!(start && busy)) begin
      if (start)
        texel_q.push_back(predict_texel(item_i));
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        item_i <= pixel_q.pop_front();
        start  <= 1'b1;
        if (calm_left != 0) begin
          calm_left <= calm_left - 1;
          idle_left <= 0;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_left <= $urandom_range(16, 48);
          idle_left <= 0;
        end else begin
          idle_left <= $urandom_range(0, 4);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobe is checked against the oldest prediction
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (texel_q.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = texel_q.pop_front();
        if (result_o.draw !== want.draw)
          report_mismatch($sformatf("draw %0b, expected %0b", result_o.draw, want.draw));
        if (result_o.texel_col !== want.texel_col)
          report_mismatch($sformatf("texel_col %0d, expected %0d",
                                    result_o.texel_col, want.texel_col));
        if (result_o.texel_row !== want.texel_row)
          report_mismatch($sformatf("texel_row %0d, expected %0d",
                                    result_o.texel_row, want.texel_row));
        pixels_checked++;
      end
    end
  end

  // one register write on the configuration channel, block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEX_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_TEX_WIDTH)
      tex_w_cfg = val;
    else
      tex_h_cfg = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pixel_q.size() != 0 || start || texel_q.size() != 0);
  endtask

  function automatic item_t make_pixel(input logic [FACE_W-1:0] face, input int frac,
                                       input int lh, input int row);
    item_t px;
    px.face        = face;
    px.wall_frac   = frac[FRAC_IN_W-1:0];
    px.line_height = lh[LH_W-1:0];
    px.screen_row  = row[ROW_W-1:0];
    return px;
  endfunction

  // random pixel, mostly inside or on the edge of its column's span
  function automatic item_t random_pixel();
    int unsigned sel, lh, half, lo, hi, row;
    sel = $urandom_range(0, 9);
    if (sel < 2)
      lh = $urandom_range(0, 3);
    else if (sel < 7)
      lh = $urandom_range(4, 700);
    else if (sel < 8)
      lh = $urandom_range(480, 1100);
    else
      lh = $urandom_range(0, 65535);
    half = lh / 2;
    lo   = (half > CENTRE_ROW) ? 0 : CENTRE_ROW - half;
    hi   = (CENTRE_ROW + half > SCREEN_H - 1) ? SCREEN_H - 1 : CENTRE_ROW + half;
    sel  = $urandom_range(0, 9);
    case (sel)
      0: row = lo;
      1: row = hi;
      2: row = (lo > 0) ? lo - 1 : ((hi < SCREEN_H - 1) ? hi + 1 : hi);
      3: row = (hi < SCREEN_H - 1) ? hi + 1 : lo;
      4, 5, 6: row = $urandom_range(hi, lo);
      default: row = $urandom_range(0, SCREEN_H - 1);
    endcase
    return make_pixel(FACE_W'($urandom_range(0, 3)), $urandom_range(0, 65535), lh, row);
  endfunction

  // stimulus and end of run
  initial begin
    logic [TEX_W-1:0] width_set [ROUNDS];
    logic [TEX_W-1:0] height_set[ROUNDS];
    width_set  = '{11'd1, 11'd3, 11'd0, 11'd2047, 11'd2047, 11'd1024, 11'd0, 11'd0};
    height_set = '{11'd1, 11'd3, 11'd5, 11'd0,    11'd2047, 11'd1,    11'd0, 11'd0};
    width_set[6]  = TEX_W'($urandom_range(0, 2047));
    height_set[6] = TEX_W'($urandom_range(0, 2047));
    width_set[7]  = TEX_W'($urandom_range(2, 200));
    height_set[7] = TEX_W'($urandom_range(2, 200));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed pixels at the reset texture size of 64 by 64
    pixel_q.push_back(make_pixel(FACE_NORTH, 0, 64, CENTRE_ROW));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 0, 64, CENTRE_ROW));
    pixel_q.push_back(make_pixel(FACE_EAST,  0, 64, CENTRE_ROW));
    pixel_q.push_back(make_pixel(FACE_WEST,  0, 64, CENTRE_ROW));
    pixel_q.push_back(make_pixel(FACE_NORTH, 65535, 64, 250));
    pixel_q.push_back(make_pixel(FACE_WEST,  65535, 64, 260));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 32768, 0, CENTRE_ROW));
    pixel_q.push_back(make_pixel(FACE_EAST,  32768, 0, CENTRE_ROW - 1));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 1234, 64, CENTRE_ROW - 32));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 1234, 64, CENTRE_ROW + 32));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 1234, 64, CENTRE_ROW + 31));
    pixel_q.push_back(make_pixel(FACE_WEST,  40000, 65535, 0));
    pixel_q.push_back(make_pixel(FACE_NORTH, 40000, 65535, SCREEN_H - 1));
    pixel_q.push_back(make_pixel(FACE_EAST,  1, 1, CENTRE_ROW));
    pixel_q.push_back(make_pixel(FACE_EAST,  1, 1, CENTRE_ROW + 1));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 777, 2, CENTRE_ROW - 1));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 777, 2, CENTRE_ROW + 1));
    pixel_q.push_back(make_pixel(FACE_WEST,  21845, 512, SCREEN_H - 1));
    pixel_q.push_back(make_pixel(FACE_NORTH, 21845, 513, 0));
    pixel_q.push_back(make_pixel(FACE_SOUTH, 32768, 100, 300));
    pixel_q.push_back(make_pixel(FACE_EAST,  65535, 100, 205));
    wait_drained();
    settings_done++;

    // random pixels over a range of texture sizes
    for (int s = 0; s < ROUNDS; s++) begin
      write_reg(REG_TEX_WIDTH,  width_set[s]);
      write_reg(REG_TEX_HEIGHT, height_set[s]);
      @(negedge clk_i);
      for (int n = 0; n < ROUND_PIX; n++)
        pixel_q.push_back(random_pixel());
      wait_drained();
      settings_done++;
    end

    // nothing further may arrive once the pipeline has emptied
    repeat (LATENCY + 10) @(posedge clk_i);
    if (texel_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", texel_q.size()));

    $display("tb: %0d pixel transactions checked over %0d texture size settings",
             pixels_checked, settings_done);
    $display("tb: %0d mismatches", mismatch_count);
    if (mismatch_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: run limit reached, %0d results still outstanding", texel_q.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule
